[sv/sfa_pkg.sv]
`default_nettype none

package sfa_pkg;

   localparam int SLOTS_DEF      = 1024;
   localparam int LEN_FIELD_DEF  = 4;

   localparam int SIZE_W         = 32;
   localparam int INDEX_W        = 10;
   localparam int LEN_W          = 16;
   localparam int NEED_W         = 18;  // two 16-bit lengths plus up to 16 header bytes
   localparam int POLICY_W       = 2;
   localparam int COUNT_W        = 11;
   localparam int CSR_INDEX_W    = 2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FIND  = 1'b1;

   localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS  = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

endpackage

`default_nettype wire

[sv/sfa_ram.sv]
`default_nettype none

module sfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/slot_fit_allocator.sv]
`default_nettype none
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  opcode, write_index, write_size, key/value length
// rsp_      out        rsp_valid / rsp_stall  slot_found, chosen_slot
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// A write item writes the table when it is taken (if its index is in range), then loads the result register.
// A find item reads the N slots in use, one table read per cycle on
// the single read port; first fit and an exact best-fit match stop the scan early.
// One item is in work at a time; the result register holds a finished item while the
// next one is taken. Reset clears control and the CSR registers; table contents stay undefined.

module slot_fit_allocator
   import sfa_pkg::*;
#(
   parameter int SLOTS              = SLOTS_DEF,
   parameter int LENGTH_FIELD_BYTES = LEN_FIELD_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic                     req_opcode,
   input  wire logic [INDEX_W-1:0]       req_write_index,
   input  wire logic signed [SIZE_W-1:0] req_write_size,
   input  wire logic [LEN_W-1:0]         req_key_length,
   input  wire logic [LEN_W-1:0]         req_value_length,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_slot_found,
   output      logic [INDEX_W-1:0]       rsp_chosen_slot,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [COUNT_W-1:0]       csr_data
);

   localparam int AW    = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int IW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int LIM_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [NEED_W-1:0] HDR_BYTES = NEED_W'(2 * LENGTH_FIELD_BYTES);

   state_type state_ff, state_in;

   logic [POLICY_W-1:0]      policy_ff, policy_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [POLICY_W-1:0]      mode_ff, mode_in;
   logic [NEED_W-1:0]        need_ff, need_in;
   logic [CNT_W-1:0]         limit_ff, limit_in;
   logic [CNT_W-1:0]         iss_ff, iss_in;
   logic                     chk_vld_ff, chk_vld_in;
   logic [AW-1:0]            chk_idx_ff, chk_idx_in;
   logic                     have_ff, have_in;
   logic signed [SIZE_W-1:0] keep_ff, keep_in;
   logic [AW-1:0]            at_ff, at_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0]       rsp_slot_ff, rsp_slot_in;

   logic                     accept;
   logic                     out_free;
   logic                     rd_en;
   logic                     wr_en;
   logic [IW-1:0]            wr_idx_wide;
   logic signed [SIZE_W-1:0] rd_data;
   logic signed [SIZE_W-1:0] need_s;
   logic                     cand;
   logic                     stop;
   logic                     scan_end;
   logic [LIM_W-1:0]         count_wide;
   logic [LIM_W-1:0]         limit_wide;
   logic [IW-1:0]            at_wide;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = (state_ff == ST_IDLE);

   assign wr_idx_wide = IW'(req_write_index);
   assign wr_en       = accept && (req_opcode == OP_WRITE) && (wr_idx_wide < IW'(SLOTS));

   // saturate the slot count to the table depth
   assign count_wide = LIM_W'(count_ff);
   assign limit_wide = (count_wide > LIM_W'(SLOTS)) ? LIM_W'(SLOTS) : count_wide;

   assign need_s = $signed(SIZE_W'(need_ff));
   assign cand   = chk_vld_ff && (rd_data > 0) && (rd_data >= need_s);

   always_comb begin
      case (mode_ff)
         FIT_BEST:  stop = cand && (rd_data == need_s);
         FIT_WORST: stop = 1'b0;
         default:   stop = cand;
      endcase
   end

   assign scan_end = !rd_en && !chk_vld_ff;
   assign at_wide  = IW'(at_ff);

   sfa_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_wide[AW-1:0]),
      .wr_data (req_write_size),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_opcode == OP_FIND) && (limit_wide != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_SCAN: begin
            if (stop || scan_end) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      rd_en        = 1'b0;
      policy_in    = policy_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      need_in      = need_ff;
      limit_in     = limit_ff;
      iss_in       = iss_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      have_in      = have_ff;
      keep_in      = keep_ff;
      at_in        = at_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POLICY: policy_in = csr_data[POLICY_W-1:0];
            CSR_SLOTS:  count_in  = csr_data;
            default:    ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = policy_ff;
               need_in  = NEED_W'(req_key_length) + NEED_W'(req_value_length) + HDR_BYTES;
               limit_in = limit_wide[CNT_W-1:0];
               iss_in   = '0;
               have_in  = 1'b0;
               at_in    = '0;
            end
         end
         ST_SCAN: begin
            rd_en = (iss_ff < limit_ff) && !stop;
            if (rd_en) begin
               iss_in     = iss_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[AW-1:0];
            end
            if (stop) begin
               have_in = 1'b1;
               at_in   = chk_idx_ff;
            end else if (cand) begin
               case (mode_ff)
                  FIT_BEST: begin
                     if (!have_ff || (rd_data < keep_ff)) begin
                        have_in = 1'b1;
                        keep_in = rd_data;
                        at_in   = chk_idx_ff;
                     end
                  end
                  FIT_WORST: begin
                     if (!have_ff || (rd_data > keep_ff)) begin
                        have_in = 1'b1;
                        keep_in = rd_data;
                        at_in   = chk_idx_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = have_ff;
               rsp_slot_in  = have_ff ? at_wide[INDEX_W-1:0] : '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= FIT_FIRST;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      need_ff      <= need_in;
      limit_ff     <= limit_in;
      iss_ff       <= iss_in;
      chk_idx_ff   <= chk_idx_in;
      have_ff      <= have_in;
      keep_ff      <= keep_in;
      at_ff        <= at_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_found  = rsp_found_ff;
   assign rsp_chosen_slot = rsp_slot_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

   a_check_follows_read: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> $past(rd_en))
      else $error("table check without a preceding read");

   a_result_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("result loaded outside hold");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && have_ff) |-> (CNT_W'(at_ff) < limit_ff))
      else $error("chosen slot beyond searched range");

endmodule

`default_nettype wire
